// ===== hdl/uvs_pkg.sv =====
package uvs_pkg;

  localparam int MAX_GRID = 1024;
  localparam int COUNT_W  = 11;
  localparam int IDX_W    = 10;
  localparam int DEN_W    = 10;
  localparam int QUO_W    = 25;
  localparam int NUM_W    = QUO_W + DEN_W;
  localparam int PHASE_W  = 24;
  localparam int MAG_W    = 31;
  localparam int SIN_LAT  = 16;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  typedef enum logic [1:0] {
    REG_RADIUS       = 2'd0,
    REG_RING_COUNT   = 2'd1,
    REG_SECTOR_COUNT = 2'd2
  } reg_index_t;

  // sine or cosine of one phase: Q30 magnitude and sign
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } sin_out_t;

endpackage

// ===== hdl/uv_sphere_vertex_generator.sv =====
// throughput: one item per cycle while s_tready is high; 25 divider stages, 16 sine stages, 2 scaling stages
// an output register plus a skid register part the two sides, s_tready is registered
// rst (synchronous) empties the pipeline and sets radius 1.0, 16 rings, 16 sectors
// counts are taken clamped: rings 3..1024, sectors 4..1024
module uv_sphere_vertex_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // ring_index, sector_index
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                  // tex_u, tex_v, upper_index, lower_index
  output logic [1:0]   m_tuser    // has_quad, in_range
);
  import uvs_pkg::*;

  localparam int SIDE_LAT = QUO_W + SIN_LAT + 2;
  localparam int TEX_LAT  = SIN_LAT + 2;
  localparam logic [23:0] QUARTER = 24'h400000;

  typedef struct packed {
    logic        valid;
    logic        in_range;
    logic        has_quad;
    logic [19:0] upper;
    logic [19:0] lower;
  } side_t;

  logic [15:0]        radius;
  logic [COUNT_W-1:0] ring_count;
  logic [COUNT_W-1:0] sector_count;
  logic [COUNT_W-1:0] nr;
  logic [COUNT_W-1:0] ns;
  logic [DEN_W-1:0]   dr;
  logic [DEN_W-1:0]   ds;
  logic [IDX_W-1:0]   ring;
  logic [IDX_W-1:0]   sector;
  logic [NUM_W-1:0]   num_th;
  logic [NUM_W-1:0]   num_ph;
  logic [NUM_W-1:0]   num_tu;
  logic [NUM_W-1:0]   num_tv;
  logic [QUO_W-1:0]   quo_th;
  logic [QUO_W-1:0]   quo_ph;
  logic [QUO_W-1:0]   quo_tu;
  logic [QUO_W-1:0]   quo_tv;
  logic [20:0]        upper_full;
  logic [20:0]        lower_full;
  side_t              side_in;
  side_t              side_q [SIDE_LAT];
  logic [16:0]        tu_q [TEX_LAT];
  logic [16:0]        tv_q [TEX_LAT];
  logic               en;
  sin_out_t           sin_th;
  sin_out_t           cos_th;
  sin_out_t           sin_ph;
  sin_out_t           cos_ph;
  logic [62:0]        prod_x;
  logic [62:0]        prod_z;
  logic [MAG_W-1:0]   mag1 [3];
  logic               neg1 [3];
  logic [17:0]        pm2 [3];
  logic [15:0]        nm2 [3];
  logic               neg2 [3];
  logic [16:0]        pos_o [3];
  logic [15:0]        norm_o [3];
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  side_t              last;
  logic [175:0]       pd;
  logic [1:0]         pu;
  logic               out_valid;
  logic [175:0]       out_data;
  logic [1:0]         out_user;
  logic               skid_valid;
  logic [175:0]       skid_data;
  logic [1:0]         skid_user;

  function automatic logic [17:0] pos_mag(input logic [MAG_W-1:0] m, input logic [15:0] rad);
    logic [48:0] p;
    p = 49'(m) * 49'(rad) + 49'(1 << 29);
    return p[47:30];
  endfunction

  function automatic logic [15:0] norm_mag(input logic [MAG_W-1:0] m, input logic neg);
    logic [31:0] s;
    logic [16:0] r;
    s = 32'(m) + 32'd16384;
    r = s[31:15];
    if (!neg && r > 17'd32767) r = 17'd32767;
    if (neg && r > 17'd32768) r = 17'd32768;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= 16'd256;
      ring_count   <= 11'd16;
      sector_count <= 11'd16;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_RADIUS:       radius       <= cfg_data;
        REG_RING_COUNT:   ring_count   <= cfg_data[COUNT_W-1:0];
        REG_SECTOR_COUNT: sector_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign nr = (ring_count < 11'd3) ? 11'd3 :
              ((ring_count > 11'(MAX_GRID)) ? 11'(MAX_GRID) : ring_count);
  assign ns = (sector_count < 11'd4) ? 11'd4 :
              ((sector_count > 11'(MAX_GRID)) ? 11'(MAX_GRID) : sector_count);
  assign dr = DEN_W'(nr - 11'd1);
  assign ds = DEN_W'(ns - 11'd1);

  assign ring   = s_tdata[9:0];
  assign sector = s_tdata[19:10];

  // rounded quotients: half the divisor added up front
  assign num_th = (NUM_W'(ring) << 23) + NUM_W'(dr >> 1);
  assign num_ph = (NUM_W'(sector) << 24) + NUM_W'(ds >> 1);
  assign num_tu = (NUM_W'(sector) << 16) + NUM_W'(ds >> 1);
  assign num_tv = (NUM_W'(ring) << 16) + NUM_W'(dr >> 1);

  assign en       = !skid_valid;
  assign s_tready = en;

  uvs_divider #(.QUO_W(QUO_W), .DEN_W(DEN_W)) u_div_th (
    .clk(clk), .en(en), .num(num_th), .den(dr), .quo(quo_th));
  uvs_divider #(.QUO_W(QUO_W), .DEN_W(DEN_W)) u_div_ph (
    .clk(clk), .en(en), .num(num_ph), .den(ds), .quo(quo_ph));
  uvs_divider #(.QUO_W(QUO_W), .DEN_W(DEN_W)) u_div_tu (
    .clk(clk), .en(en), .num(num_tu), .den(ds), .quo(quo_tu));
  uvs_divider #(.QUO_W(QUO_W), .DEN_W(DEN_W)) u_div_tv (
    .clk(clk), .en(en), .num(num_tv), .den(dr), .quo(quo_tv));

  assign upper_full = 21'(ring) * 21'(ns) + 21'(sector);
  assign lower_full = upper_full + 21'(ns);

  always_comb begin
    side_in.valid    = s_tvalid;
    side_in.in_range = (11'(ring) < nr) && (11'(sector) < ns);
    side_in.has_quad = (ring < dr) && (sector < ds);
    side_in.upper    = upper_full[19:0];
    side_in.lower    = lower_full[19:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE_LAT; i++) side_q[i].valid <= 1'b0;
    end else if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < SIDE_LAT; i++) side_q[i] <= side_q[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tu_q[0] <= quo_tu[16:0];
      tv_q[0] <= quo_tv[16:0];
      for (int i = 1; i < TEX_LAT; i++) begin
        tu_q[i] <= tu_q[i-1];
        tv_q[i] <= tv_q[i-1];
      end
    end
  end

  uvs_sine u_sin_th (.clk(clk), .en(en), .phase(quo_th[23:0]), .result(sin_th));
  uvs_sine u_cos_th (.clk(clk), .en(en), .phase(quo_th[23:0] + QUARTER), .result(cos_th));
  uvs_sine u_sin_ph (.clk(clk), .en(en), .phase(quo_ph[23:0]), .result(sin_ph));
  uvs_sine u_cos_ph (.clk(clk), .en(en), .phase(quo_ph[23:0] + QUARTER), .result(cos_ph));

  assign prod_x = 63'(cos_ph.mag) * 63'(sin_th.mag) + 63'(1 << 29);
  assign prod_z = 63'(sin_ph.mag) * 63'(sin_th.mag) + 63'(1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      mag1[0] <= prod_x[60:30];
      neg1[0] <= cos_ph.neg ^ sin_th.neg;
      mag1[1] <= cos_th.mag;
      neg1[1] <= !cos_th.neg;
      mag1[2] <= prod_z[60:30];
      neg1[2] <= sin_ph.neg ^ sin_th.neg;
      for (int k = 0; k < 3; k++) begin
        pm2[k]  <= pos_mag(mag1[k], radius);
        nm2[k]  <= norm_mag(mag1[k], neg1[k]);
        neg2[k] <= neg1[k];
      end
    end
  end

  assign last = side_q[SIDE_LAT-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_o[k]  = neg2[k] ? 17'(18'd0 - pm2[k]) : pm2[k][16:0];
      norm_o[k] = neg2[k] ? 16'(16'd0 - nm2[k]) : nm2[k];
    end
    tex_u = 17'd65536 - tu_q[TEX_LAT-1];
    tex_v = 17'd65536 - tv_q[TEX_LAT-1];
    pd = {3'b000, last.lower, last.upper, tex_v, tex_u,
          norm_o[2], norm_o[1], norm_o[0], pos_o[2], pos_o[1], pos_o[0]};
    pu = {1'b1, last.has_quad};
    // a point outside the grid gives an all-zero item
    if (!last.in_range) begin
      pd = '0;
      pu = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= last.valid;
      end
    end else if (last.valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_data <= skid_valid ? skid_data : pd;
      out_user <= skid_valid ? skid_user : pu;
    end else if (en) begin
      skid_data <= pd;
      skid_user <= pu;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an item while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_tready))
    else $error("skid register filled without an output stall");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    last.valid && !skid_valid && !out_valid |=> out_valid)
    else $error("finished item not moved to the output register");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
    else $error("out of range item carries nonzero fields");

  a_quad_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[1])
    else $error("quad flagged for a point outside the grid");

endmodule

// ===== hdl/uvs_divider.sv =====
module uvs_divider #(
  parameter int QUO_W = uvs_pkg::QUO_W,
  parameter int DEN_W = uvs_pkg::DEN_W
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [QUO_W+DEN_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);
  import uvs_pkg::*;

  // one quotient bit per stage; the user must keep the divisor static configuration, the block does not enforce it
  logic [DEN_W-1:0] rem  [QUO_W];
  logic [QUO_W-1:0] low  [QUO_W];
  logic [QUO_W-1:0] part [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] part_in;
    logic [DEN_W:0]   trial;
    logic             fits;

    if (i == 0) begin : g_first
      assign rem_in  = num[QUO_W+DEN_W-1:QUO_W];
      assign low_in  = num[QUO_W-1:0];
      assign part_in = '0;
    end else begin : g_next
      assign rem_in  = rem[i-1];
      assign low_in  = low[i-1];
      assign part_in = part[i-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        low[i]  <= {low_in[QUO_W-2:0], 1'b0};
        part[i] <= {part_in[QUO_W-2:0], fits};
      end
    end
  end

  assign quo = part[QUO_W-1];

endmodule

// ===== hdl/uvs_sine.sv =====
module uvs_sine (
  input  logic                           clk,
  input  logic                           en,
  input  logic [uvs_pkg::PHASE_W-1:0]    phase,
  output uvs_pkg::sin_out_t              result
);
  import uvs_pkg::*;

  typedef struct packed {
    logic        neg;
    logic [30:0] t;
    logic [31:0] t2;
  } carry_t;

  logic [22:0] x0;
  logic [22:0] x_q;
  logic        neg_p0;
  logic [53:0] t_prod;
  logic [30:0] t_q;
  logic        neg_p1;
  logic [61:0] t2_prod;
  carry_t      c [4];
  carry_t      c_p2;
  logic [30:0] u [4];
  logic [61:0] m_prod;

  // quarter wave: mirror in odd quadrants
  assign x0 = phase[22] ? 23'(24'h400000 - {2'b0, phase[21:0]}) : {1'b0, phase[21:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      x_q    <= x0;
      neg_p0 <= phase[23];
    end
  end

  assign t_prod = 54'(x_q) * 54'(HALF_PI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      t_q    <= t_prod[52:22];
      neg_p1 <= neg_p0;
    end
  end

  assign t2_prod = 62'(t_q) * 62'(t_q);

  always_ff @(posedge clk) begin
    if (en) begin
      c_p2.neg <= neg_p1;
      c_p2.t   <= t_q;
      c_p2.t2  <= t2_prod[61:30];
    end
  end

  assign c[0] = c_p2;
  assign u[0] = ONE_Q30;

  // series terms: divide by 42, 20, 6 through a reciprocal with one correction
  for (genvar r = 0; r < 3; r++) begin : g_round
    localparam logic [31:0] DIV   = (r == 0) ? 32'd42 : ((r == 1) ? 32'd20 : 32'd6);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

    logic [62:0] a_prod;
    logic [63:0] q_prod;
    logic [31:0] back;
    logic [31:0] u_full;
    carry_t      cm;
    carry_t      cd1;
    carry_t      cd2;
    carry_t      cd3;
    logic [31:0] a_m;
    logic [31:0] a_d1;
    logic [31:0] q0_d1;
    logic [31:0] q0_d2;
    logic [7:0]  rem_d2;
    logic [30:0] u_d3;

    assign a_prod = 63'(c[r].t2) * 63'(u[r]);
    assign q_prod = 64'(a_m) * 64'(RECIP);
    assign back   = 32'(q0_d1 * DIV);
    assign u_full = 32'(ONE_Q30) - q0_d2 - 32'(rem_d2 >= 8'(DIV));

    always_ff @(posedge clk) begin
      if (en) begin
        a_m    <= a_prod[61:30];
        cm     <= c[r];
        q0_d1  <= q_prod[63:32];
        a_d1   <= a_m;
        cd1    <= cm;
        rem_d2 <= 8'(a_d1 - back);
        q0_d2  <= q0_d1;
        cd2    <= cd1;
        u_d3   <= u_full[30:0];
        cd3    <= cd2;
      end
    end

    assign c[r+1] = cd3;
    assign u[r+1] = u_d3;
  end

  assign m_prod = 62'(c[3].t) * 62'(u[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      result.mag <= m_prod[60:30];
      result.neg <= c[3].neg;
    end
  end

endmodule

// ===== verif/uv_sphere_vertex_generator_test.sv =====
module uv_sphere_vertex_generator_test;
  import uvs_pkg::*;

  typedef longint unsigned u64;

  // m_tdata layout, highest field first
  typedef struct packed {
    logic [19:0] lower_index;
    logic [19:0] upper_index;
    logic [16:0] tex_v;
    logic [16:0] tex_u;
    logic [15:0] norm_z;
    logic [15:0] norm_y;
    logic [15:0] norm_x;
    logic [16:0] pos_z;
    logic [16:0] pos_y;
    logic [16:0] pos_x;
  } vertex_t;

  typedef struct packed {
    vertex_t    v;
    logic       in_range;
    logic       has_quad;
  } vertex_result_t;

  localparam int LATENCY_WAIT = 60;
  localparam int STALL_LIMIT  = 3000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = REG_RADIUS;
  logic [15:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [23:0]  s_tdata = '0;   // ring_index, sector_index
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [175:0] m_tdata;        // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                // tex_u, tex_v, upper_index, lower_index
  logic [1:0]   m_tuser;        // has_quad, in_range

  uv_sphere_vertex_generator dut (.*);

  always #6 clk = ~clk;

  // shadow copy of the registers
  u64 radius_q88 = 256;
  u64 ring_cfg   = 16;
  u64 sector_cfg = 16;

  vertex_result_t vertex_queue[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  cfg_writes = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  int  rx_cycle = 0;
  int  rx_mode = 0;

  function automatic u64 quarter_sine(u64 x);
    u64 t, t2, u;
    t  = (x * 64'd1686629713) >> 22;
    t2 = (t * t) >> 30;
    u  = 64'd1073741824 - t2 / 42;
    u  = 64'd1073741824 - ((t2 * u) >> 30) / 20;
    u  = 64'd1073741824 - ((t2 * u) >> 30) / 6;
    return (t * u) >> 30;
  endfunction

  task automatic phase_sine(input u64 p, output u64 mag, output bit neg);
    u64 q, x;
    p   = p & 64'hFFFFFF;
    q   = p >> 22;
    x   = p & 64'h3FFFFF;
    if (q[0]) x = 64'h400000 - x;
    mag = quarter_sine(x);
    neg = (q >= 2);
  endtask

  function automatic logic [15:0] scale_normal(u64 mag, bit neg);
    u64 r;
    r = (mag + (64'd1 << 14)) >> 15;
    if (!neg && r > 32767) r = 32767;
    if (neg && r > 32768) r = 32768;
    return neg ? 16'(0 - r) : 16'(r);
  endfunction

  function automatic logic [16:0] scale_position(u64 mag, bit neg);
    u64 r;
    r = (mag * radius_q88 + (64'd1 << 29)) >> 30;
    return neg ? 17'(0 - r) : 17'(r);
  endfunction

  function automatic u64 clamp_count(u64 v, u64 lo);
    if (v < lo) return lo;
    if (v > MAX_GRID) return MAX_GRID;
    return v;
  endfunction

  task automatic predict_vertex(input u64 ring, input u64 sector,
                                output vertex_result_t e);
    u64 nr, ns, dr, ds, th, ph, st, ct, sp, cp, m;
    bit nst, nct, nsp, ncp;
    nr = clamp_count(ring_cfg, 3);
    ns = clamp_count(sector_cfg, 4);
    dr = nr - 1;
    ds = ns - 1;
    e  = '0;
    if (ring >= nr || sector >= ns) return;
    th = (ring * (64'd1 << 23) + dr / 2) / dr;
    ph = (sector * (64'd1 << 24) + ds / 2) / ds;
    phase_sine(th, st, nst);
    phase_sine(th + 64'h400000, ct, nct);
    phase_sine(ph, sp, nsp);
    phase_sine(ph + 64'h400000, cp, ncp);
    m = (cp * st + (64'd1 << 29)) >> 30;
    e.v.pos_x  = scale_position(m, ncp != nst);
    e.v.norm_x = scale_normal(m, ncp != nst);
    e.v.pos_y  = scale_position(ct, !nct);
    e.v.norm_y = scale_normal(ct, !nct);
    m = (sp * st + (64'd1 << 29)) >> 30;
    e.v.pos_z  = scale_position(m, nsp != nst);
    e.v.norm_z = scale_normal(m, nsp != nst);
    e.v.tex_u  = 17'(65536 - (sector * 65536 + ds / 2) / ds);
    e.v.tex_v  = 17'(65536 - (ring * 65536 + dr / 2) / dr);
    e.v.upper_index = 20'(ring * ns + sector);
    e.v.lower_index = 20'((ring + 1) * ns + sector);
    e.has_quad = (ring < dr && sector < ds);
    e.in_range = 1'b1;
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on vertex %0d, %s: expected %0h, got %0h",
                 results_seen, name, want, got);
    end
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    vertex_result_t want;
    vertex_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = vertex_t'(m_tdata[172:0]);
      if (vertex_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex result %h", m_tdata);
      end else begin
        want = vertex_queue.pop_front();
        check_field("pos_x", want.v.pos_x, got.pos_x);
        check_field("pos_y", want.v.pos_y, got.pos_y);
        check_field("pos_z", want.v.pos_z, got.pos_z);
        check_field("norm_x", want.v.norm_x, got.norm_x);
        check_field("norm_y", want.v.norm_y, got.norm_y);
        check_field("norm_z", want.v.norm_z, got.norm_z);
        check_field("tex_u", want.v.tex_u, got.tex_u);
        check_field("tex_v", want.v.tex_v, got.tex_v);
        check_field("upper_index", want.v.upper_index, got.upper_index);
        check_field("lower_index", want.v.lower_index, got.lower_index);
        check_field("pad", 0, m_tdata[175:173]);
        check_field("has_quad", want.has_quad, m_tuser[0]);
        check_field("in_range", want.in_range, m_tuser[1]);
      end
      results_seen++;
    end
    rx_cycle++;
    if (rx_cycle % 150 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("uv_sphere_vertex_generator_test NOT OK");
      $finish;
    end
  end

  task automatic send_point(input int ring, input int sector);
    vertex_result_t e;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_tdata  <= {4'b0, sector[9:0], ring[9:0]};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_vertex(u64'(ring[9:0]), u64'(sector[9:0]), e);
    vertex_queue.insert(vertex_queue.size(), e);
    items_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RADIUS:     radius_q88 = value & 16'hFFFF;
      REG_RING_COUNT: ring_cfg   = value & 11'h7FF;
      default:        sector_cfg = value & 11'h7FF;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_sphere(input int radius, input int rings, input int sectors);
    drain();
    write_reg(REG_RADIUS, radius);
    write_reg(REG_RING_COUNT, rings);
    write_reg(REG_SECTOR_COUNT, sectors);
  endtask

  // reset settings: poles, seams, quadrants and points just outside the grid
  task automatic test_default_grid;
    send_point(0, 0);
    send_point(15, 15);
    send_point(15, 0);
    send_point(0, 15);
    send_point(14, 14);
    send_point(7, 4);
    send_point(8, 11);
    send_point(16, 0);
    send_point(0, 16);
    send_point(1023, 1023);
    send_point(3, 8);
  endtask

  // largest grid and radius, including the wrapped lower index
  task automatic test_large_grid;
    set_sphere(16'hFFFF, 1024, 1024);
    send_point(1023, 1023);
    send_point(1022, 1022);
    send_point(511, 256);
    send_point(0, 767);
    send_point(1, 1);
    send_point(682, 341);
  endtask

  // counts below and above the legal span act as the nearest bound
  task automatic test_clamped_counts;
    set_sphere(0, 2, 0);
    send_point(2, 3);
    send_point(1, 2);
    send_point(3, 0);
    send_point(0, 4);
    set_sphere(16'h8001, 2047, 1500);
    send_point(1023, 1023);
    send_point(512, 0);
  endtask

  task automatic test_random_points(input int count);
    int nr, ns, r, s, n;
    for (n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 3))
          0: set_sphere($urandom, $urandom_range(3, 40), $urandom_range(4, 40));
          1: set_sphere($urandom, $urandom_range(0, 2047), $urandom_range(0, 2047));
          2: set_sphere($urandom, 1024, 1024);
          default: set_sphere($urandom, $urandom_range(3, 1024), $urandom_range(4, 1024));
        endcase
      end
      nr = int'(clamp_count(ring_cfg, 3));
      ns = int'(clamp_count(sector_cfg, 4));
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 1023);
        s = $urandom_range(0, 1023);
      end else begin
        r = $urandom_range(0, nr - 1);
        s = $urandom_range(0, ns - 1);
      end
      send_point(r, s);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_grid();
    test_large_grid();
    test_clamped_counts();
    test_random_points(600);
    drain();
    $display("sent %0d grid points, checked %0d vertices over %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("covered default, largest, clamped and random sphere settings");
    if (mismatches == 0 && vertex_queue.size() == 0) begin
      $display("uv_sphere_vertex_generator_test OK");
    end else begin
      $display("%0d mismatches, %0d vertices missing", mismatches, vertex_queue.size());
      $display("uv_sphere_vertex_generator_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/uvs_pkg.sv
hdl/uvs_divider.sv
hdl/uvs_sine.sv
hdl/uv_sphere_vertex_generator.sv
verif/uv_sphere_vertex_generator_test.sv
